@@ src/gdfs_pkg.sv @@
// Shared constants for the graph depth-first post-order block.
// No dependencies; imported by graph_dfs_postorder.
package gdfs_pkg;

    // Graph capacity
    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 8;

    // Port field widths
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    // Internal widths derived from capacity
    localparam int VERT_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int ADDR_W  = (MAX_VERTICES * MAX_DEGREE > 1) ?
                             $clog2(MAX_VERTICES * MAX_DEGREE) : 1;
    localparam int LIM_W   = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ src/graph_dfs_postorder.sv @@
// Graph store with depth-first post-order search, top level.
// Depends on gdfs_pkg for capacity, widths, action and status codes.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in      | into blk  | i_in_valid / o_in_stall  | i_action, i_vertex_a, i_vertex_b
//  out     | out of blk| o_out_valid / i_out_stall| o_vertex_out, o_last, o_status
//  cfg     | into blk  | i_cfg_we                 | i_cfg_wdata (vertex_count)
//
// Clear passes through S_DECODE and add-edge through S_DECODE and S_ADD2. A search
//   reads the neighbor memory through its registered read port: each list entry
//   is read in S_STEP and compared, maybe pushed, in S_SCAN; each vertex is
//   popped in S_STEP.
// One transaction is worked at a time; o_in_stall is high until it is done.
// Reset (i_rst_n low, synchronous) empties all lists, drops any result and
//   sets vertex_count to 16. Neighbor memory contents are not cleared.
// A stall on the output holds the sequencer at its next emit; nothing is lost.
module graph_dfs_postorder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transaction channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [gdfs_pkg::ACTION_W-1:0]  i_action,
    input  logic [gdfs_pkg::FIELD_W-1:0]   i_vertex_a,
    input  logic [gdfs_pkg::FIELD_W-1:0]   i_vertex_b,
    // result transaction channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gdfs_pkg::FIELD_W-1:0]   o_vertex_out,
    output logic                           o_last,
    output logic [gdfs_pkg::STATUS_W-1:0]  o_status,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [gdfs_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gdfs_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0; // wait for a transaction
    localparam logic [2:0] S_DECODE = 3'd1; // check ranges, start the action
    localparam logic [2:0] S_ADD2   = 3'd2; // second half of an edge insert
    localparam logic [2:0] S_STEP   = 3'd3; // examine top of walk stack
    localparam logic [2:0] S_SCAN   = 3'd4; // neighbor read back, maybe push

    logic [2:0]            r_state, n_state;
    logic [CFG_W-1:0]      r_cfg;

    // Latched transaction
    logic [ACTION_W-1:0]   r_action;
    logic [FIELD_W-1:0]    r_va, r_vb;

    // Per-vertex state in flops
    logic [DEG_W-1:0]      r_deg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_visited;

    // Walk stack: vertex and next neighbor position
    logic [VERT_W-1:0]     r_stk_v [MAX_VERTICES];
    logic [DEG_W-1:0]      r_stk_p [MAX_VERTICES];
    logic [DEPTH_W-1:0]    r_depth, n_depth;

    // Neighbor memory, one write and one registered read port
    logic [VERT_W-1:0]     r_nbr_mem [MAX_VERTICES * MAX_DEGREE];
    logic [VERT_W-1:0]     r_rd_data;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    logic [VERT_W-1:0]     wr_data;
    logic                  mem_we;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]    r_vout;
    logic                  r_last;
    logic [STATUS_W-1:0]   r_status;

    // Combinational control
    logic                  out_free;
    logic                  emit;
    logic [FIELD_W-1:0]    emit_v;
    logic                  emit_last;
    logic [STATUS_W-1:0]   emit_status;
    logic [LIM_W-1:0]      lim;
    logic [VERT_W-1:0]     va, vb, top_idx, top_v, push_idx;
    logic [DEG_W-1:0]      top_p;
    logic                  a_bad, b_bad, room_bad;
    logic                  deg_clear, deg_inc_a, deg_inc_b;
    logic                  stk_adv, stk_push, stk_init;

    assign out_free = !r_out_valid || !i_out_stall;
    assign lim = (LIM_W'(r_cfg) > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES)
                                                        : LIM_W'(r_cfg);
    assign va       = VERT_W'(r_va);
    assign vb       = VERT_W'(r_vb);
    assign a_bad    = LIM_W'(r_va) >= lim;
    assign b_bad    = LIM_W'(r_vb) >= lim;
    // a self-loop needs two free entries in one list
    assign room_bad = (va == vb) ?
                      ((DEG_W + 1)'(r_deg[va]) + (DEG_W + 1)'(2) > (DEG_W + 1)'(MAX_DEGREE)) :
                      ((r_deg[va] >= DEG_W'(MAX_DEGREE)) || (r_deg[vb] >= DEG_W'(MAX_DEGREE)));

    assign top_idx  = VERT_W'(r_depth - DEPTH_W'(1));
    assign top_v    = r_stk_v[top_idx];
    assign top_p    = r_stk_p[top_idx];
    assign push_idx = VERT_W'(r_depth);

    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        emit        = 1'b0;
        emit_v      = '0;
        emit_last   = 1'b1;
        emit_status = ST_OK;
        mem_we      = 1'b0;
        wr_addr     = ADDR_W'(va * MAX_DEGREE) + ADDR_W'(r_deg[va]);
        wr_data     = vb;
        rd_addr     = ADDR_W'(top_v * MAX_DEGREE) + ADDR_W'(top_p);
        deg_clear   = 1'b0;
        deg_inc_a   = 1'b0;
        deg_inc_b   = 1'b0;
        stk_adv     = 1'b0;
        stk_push    = 1'b0;
        stk_init    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_action == ACT_CLEAR || r_action == ACT_ADD ||
                    r_action == ACT_SEARCH) begin
                    // every defined action answers at least once; hold for a slot
                    if (out_free) begin
                        if (r_action == ACT_CLEAR) begin
                            deg_clear = 1'b1;
                            emit      = 1'b1;
                            n_state   = S_IDLE;
                        end else if (a_bad || (r_action == ACT_ADD && b_bad)) begin
                            emit        = 1'b1;
                            emit_status = ST_RANGE;
                            n_state     = S_IDLE;
                        end else if (r_action == ACT_ADD) begin
                            if (room_bad) begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                                n_state     = S_IDLE;
                            end else begin
                                mem_we    = 1'b1;
                                deg_inc_a = 1'b1;
                                n_state   = S_ADD2;
                            end
                        end else begin
                            stk_init = 1'b1;
                            n_depth  = DEPTH_W'(1);
                            n_state  = S_STEP;
                        end
                    end
                end else begin
                    // unused code: drop silently
                    n_state = S_IDLE;
                end
            end
            S_ADD2: begin
                if (out_free) begin
                    mem_we    = 1'b1;
                    wr_addr   = ADDR_W'(vb * MAX_DEGREE) + ADDR_W'(r_deg[vb]);
                    wr_data   = va;
                    deg_inc_b = 1'b1;
                    emit      = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_STEP: begin
                if (top_p < r_deg[top_v]) begin
                    stk_adv = 1'b1;
                    n_state = S_SCAN;
                end else if (out_free) begin
                    // pop and emit in post-order; start vertex pops last
                    emit      = 1'b1;
                    emit_v    = FIELD_W'(top_v);
                    emit_last = (r_depth == DEPTH_W'(1));
                    n_depth   = r_depth - DEPTH_W'(1);
                    if (r_depth == DEPTH_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (!r_visited[r_rd_data] && r_depth < DEPTH_W'(MAX_VERTICES)) begin
                    stk_push = 1'b1;
                    n_depth  = r_depth + DEPTH_W'(1);
                end
                n_state = S_STEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = emit || (r_out_valid && i_out_stall);
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Degree counts: reset and clear empty every list at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || deg_clear) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_deg[i] <= '0;
            end
        end else if (deg_inc_a) begin
            r_deg[va] <= r_deg[va] + DEG_W'(1);
        end else if (deg_inc_b) begin
            r_deg[vb] <= r_deg[vb] + DEG_W'(1);
        end
    end

    // Visited marks: start vertex alone at search start, set on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
        end else if (stk_init) begin
            r_visited     <= '0;
            r_visited[va] <= 1'b1;
        end else if (stk_push) begin
            r_visited[r_rd_data] <= 1'b1;
        end
    end

    // Payload: latched transaction, walk stack, output register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_va     <= i_vertex_a;
            r_vb     <= i_vertex_b;
        end
        if (stk_init) begin
            r_stk_v[0] <= va;
            r_stk_p[0] <= '0;
        end else if (stk_adv) begin
            r_stk_p[top_idx] <= top_p + DEG_W'(1);
        end else if (stk_push) begin
            r_stk_v[push_idx] <= r_rd_data;
            r_stk_p[push_idx] <= '0;
        end
        if (emit) begin
            r_vout   <= emit_v;
            r_last   <= emit_last;
            r_status <= emit_status;
        end
    end

    // Neighbor memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_nbr_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_nbr_mem[rd_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_vertex_out = r_vout;
    assign o_last       = r_last;
    assign o_status     = r_status;

`ifndef ASSERT_OFF
    // the walk stack is empty whenever the block waits for work
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_depth == '0))
        else $error("walk stack not empty while idle");

    // walking states always have a top of stack
    a_walk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP || r_state == S_SCAN) |-> (r_depth != '0))
        else $error("walk with empty stack");

    // stack never grows past MAX_VERTICES
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_VERTICES))
        else $error("walk stack overflow");

    // an error answer is always a single, final result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    // a final result, of a search or of any other action, ends the transaction
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result");
`endif

endmodule
